### rtl/core/rcdr_pkg.sv
// Shared constants and types for the remote-control datagram receiver.
package rcdr_pkg;

	// Framing
	localparam logic [5:0] POS_IDLE      = 6'd32;
	localparam logic [5:0] POS_LAST      = 6'd31;
	localparam logic [5:0] ANALOG_FIRST  = 6'd4;
	localparam logic [5:0] DIGITAL_FIRST = 6'd12;
	localparam int unsigned DIGITAL_BYTES = 8;

	// Header, type and subtype
	localparam logic [7:0] HEADER0    = 8'hdf;
	localparam logic [7:0] HEADER1    = 8'h81;
	localparam logic [7:0] TYPE_OK    = 8'h00;
	localparam logic [7:0] SUBTYPE_OK = 8'h11;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HEADER  = 3'd1;
	localparam logic [2:0] ST_CHECK   = 3'd2;
	localparam logic [2:0] ST_TYPE    = 3'd3;
	localparam logic [2:0] ST_SUBTYPE = 3'd4;

	// One received byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} rcdr_item_t;

	// One status report; analog[0] is channel 1
	typedef struct packed {
		logic [2:0]        status;
		logic [3:0][15:0]  analog;
		logic [63:0]       digital;
	} rcdr_result_t;

endpackage

### rtl/core/rcdr_in_reg.sv
// Input register stage: holds one accepted byte until the frame logic takes it.
module rcdr_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rcdr_pkg::rcdr_item_t in_item,
	input  logic               take,
	output logic               valid_s1,
	output rcdr_pkg::rcdr_item_t item_s1
);
	import rcdr_pkg::*;

	// room when empty or the held byte moves on this cycle
	assign in_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/core/rcdr_frame.sv
// Frame tracking: byte position, check sums, header checks, channel capture and commit.
module rcdr_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  rcdr_pkg::rcdr_item_t item,
	input  logic [15:0]          idle_value,
	output logic                 res_valid,
	output rcdr_pkg::rcdr_result_t res
);
	import rcdr_pkg::*;

	logic [5:0]        pos_q;
	logic [7:0]        even_q;
	logic [7:0]        odd_q;
	logic [2:0]        fault_q;
	logic [63:0]       pend_analog_q;
	logic [63:0]       pend_digital_q;
	logic [3:0][15:0]  stored_analog_q;
	logic [63:0]       stored_digital_q;
	logic              loaded_q;

	logic [5:0]        pos_cur;
	logic [5:0]        pos_nxt;
	logic              active;
	logic              last;
	logic [7:0]        even_nxt;
	logic [7:0]        odd_nxt;
	logic [2:0]        fault_cur;
	logic [2:0]        fault_nxt;
	logic [63:0]       pend_analog_nxt;
	logic [63:0]       pend_digital_nxt;
	logic [2:0]        status_nxt;
	logic              report;
	logic              commit;
	logic [3:0][15:0]  analog_nxt;
	logic [63:0]       digital_nxt;
	logic              loaded_nxt;

	// absorb one byte
	always_comb begin
		pos_cur          = item.first_byte ? '0 : pos_q;
		active           = !pos_cur[5];
		last             = (pos_cur == POS_LAST);
		even_nxt         = item.first_byte ? '0 : even_q;
		odd_nxt          = item.first_byte ? '0 : odd_q;
		fault_cur        = item.first_byte ? ST_OK : fault_q;
		fault_nxt        = fault_cur;
		pend_analog_nxt  = pend_analog_q;
		pend_digital_nxt = pend_digital_q;
		pos_nxt          = pos_cur;

		if (active) begin
			if (pos_cur[0]) begin
				odd_nxt = odd_nxt ^ item.data_byte;
			end else begin
				even_nxt = even_nxt ^ item.data_byte;
			end
			if (pos_cur == 6'd0 && item.data_byte != HEADER0) begin
				fault_nxt = ST_HEADER;
			end
			if (pos_cur == 6'd1 && item.data_byte != HEADER1) begin
				fault_nxt = ST_HEADER;
			end
			if (pos_cur == 6'd2 && fault_cur == ST_OK && item.data_byte != TYPE_OK) begin
				fault_nxt = ST_TYPE;
			end
			if (pos_cur == 6'd3 && fault_cur == ST_OK && item.data_byte != SUBTYPE_OK) begin
				fault_nxt = ST_SUBTYPE;
			end
			// analog bytes shift in big-endian
			if (pos_cur >= ANALOG_FIRST && pos_cur < DIGITAL_FIRST) begin
				pend_analog_nxt = {pend_analog_q[55:0], item.data_byte};
			end
			// digital bytes land little-endian
			for (int k = 0; k < DIGITAL_BYTES; k++) begin
				if (pos_cur == DIGITAL_FIRST + 6'(k)) begin
					pend_digital_nxt[8*k +: 8] = item.data_byte;
				end
			end
			pos_nxt = last ? POS_IDLE : pos_cur + 6'd1;
		end
	end

	// verdict and commit on the last byte
	always_comb begin
		if (fault_nxt == ST_HEADER) begin
			status_nxt = ST_HEADER;
		end else if (even_nxt != 8'd0 || odd_nxt != 8'd0) begin
			status_nxt = ST_CHECK;
		end else begin
			status_nxt = fault_nxt;
		end
		report = step && active && last;
		commit = report && (status_nxt == ST_OK);
		if (commit) begin
			for (int i = 0; i < 4; i++) begin
				analog_nxt[i] = pend_analog_nxt[16*(3-i) +: 16];
			end
			digital_nxt = pend_digital_nxt;
			loaded_nxt  = 1'b1;
		end else begin
			analog_nxt  = stored_analog_q;
			digital_nxt = stored_digital_q;
			loaded_nxt  = loaded_q;
		end
	end

	// control and stored-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q            <= POS_IDLE;
			even_q           <= '0;
			odd_q            <= '0;
			fault_q          <= ST_OK;
			stored_analog_q  <= '0;
			stored_digital_q <= '0;
			loaded_q         <= 1'b0;
			res_valid        <= 1'b0;
		end else begin
			res_valid <= report;
			if (step) begin
				pos_q            <= pos_nxt;
				even_q           <= even_nxt;
				odd_q            <= odd_nxt;
				fault_q          <= fault_nxt;
				stored_analog_q  <= analog_nxt;
				stored_digital_q <= digital_nxt;
				loaded_q         <= loaded_nxt;
			end
		end
	end

	// pending capture; the report payload loads only on the last byte
	always_ff @(posedge clk) begin
		if (step) begin
			pend_analog_q  <= pend_analog_nxt;
			pend_digital_q <= pend_digital_nxt;
		end
		if (report) begin
			res.status     <= status_nxt;
			for (int i = 0; i < 4; i++) begin
				res.analog[i] <= loaded_nxt ? analog_nxt[i] : idle_value;
			end
			res.digital    <= digital_nxt;
		end
	end

endmodule

### rtl/core/rc_datagram_receiver.sv
// Top level of the remote-control datagram receiver.
// The report for byte 31 goes through the input register, result register and out_valid flag.
// Throughput: one byte per cycle; bytes stall only while a finished report waits for out_ready.
// A report holds its place in the result register while the next bytes are taken.
// Reset (arst_n low, asynchronous): framing idle, check sums and faults cleared,
// stored channels zero, idle analog value zero, no report pending.
module rc_datagram_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] analog_ch1,
	output logic [15:0] analog_ch2,
	output logic [15:0] analog_ch3,
	output logic [15:0] analog_ch4,
	output logic [63:0] digital_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import rcdr_pkg::*;

	rcdr_item_t   in_item;
	rcdr_item_t   item_s1;
	logic         valid_s1;
	logic         take;
	logic         step;
	logic         res_valid;
	rcdr_result_t res;
	logic [15:0]  idle_value_q;
	logic         out_valid_q;

	assign in_item.data_byte  = data_byte;
	assign in_item.first_byte = first_byte;

	// byte moves into the frame logic when the result register can take a report
	assign take = !out_valid_q || out_ready;
	assign step = valid_s1 && take;

	rcdr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rcdr_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.idle_value (idle_value_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// configuration register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_value_q <= '0;
		end else if (cfg_valid) begin
			idle_value_q <= cfg_data;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res.status;
	assign analog_ch1   = res.analog[0];
	assign analog_ch2   = res.analog[1];
	assign analog_ch3   = res.analog[2];
	assign analog_ch4   = res.analog[3];
	assign digital_bits = res.digital;

endmodule

### sim/tb.sv
// Testbench for the remote-control datagram receiver: directed frames, then random traffic.
`timescale 1ns / 100ps

module tb;
	import rcdr_pkg::*;

	localparam int LIMIT_CYCLES    = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 4;
	localparam int RANDOM_ITEMS    = 850;

	// Frame corruption flags
	localparam logic [4:0] FAULT_NONE    = 5'b00000;
	localparam logic [4:0] FAULT_HDR0    = 5'b00001;
	localparam logic [4:0] FAULT_HDR1    = 5'b00010;
	localparam logic [4:0] FAULT_TYPE    = 5'b00100;
	localparam logic [4:0] FAULT_SUBTYPE = 5'b01000;
	localparam logic [4:0] FAULT_CHECK   = 5'b10000;

	typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	// One directed frame: optional idle-value write first, then an optional
	// cut-off prefix, the frame itself, and ignored trailing bytes.
	typedef struct packed {
		logic        cfg_en;
		logic [15:0] cfg_val;
		fill_t       fill;
		logic [4:0]  faults;
		logic [5:0]  cut;
		logic [2:0]  trail;
		logic        typed;
		logic [2:0]  typed_status;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [15:0] analog_ch1;
	logic [15:0] analog_ch2;
	logic [15:0] analog_ch3;
	logic [15:0] analog_ch4;
	logic [63:0] digital_bits;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	rc_datagram_receiver DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.analog_ch1   (analog_ch1),
		.analog_ch2   (analog_ch2),
		.analog_ch3   (analog_ch3),
		.analog_ch4   (analog_ch4),
		.digital_bits (digital_bits),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver state mirror
	logic [5:0]  frame_pos = POS_IDLE;
	logic [7:0]  even_sum = '0;
	logic [7:0]  odd_sum = '0;
	logic [2:0]  frame_fault = ST_OK;
	logic [63:0] next_analog = '0;
	logic [63:0] next_digital = '0;
	logic [15:0] held_analog [4] = '{16'h0, 16'h0, 16'h0, 16'h0};
	logic [63:0] held_digital = '0;
	logic        held_valid = 1'b0;
	logic [15:0] idle_value = '0;

	rcdr_result_t expected_reports [$];
	frame_row_t   directed_rows [$];
	logic [7:0]   frame_buf [32];

	int  mismatch_count = 0;
	int  items_sent = 0;
	int  cycle_count;
	bit  hold_off_request = 1'b0;
	bit  typed_en = 1'b0;
	logic [2:0] typed_st = ST_OK;

	// Advance the mirror by one accepted byte; fires on byte 31 of a frame
	task automatic datagram_absorb(input logic [7:0] b, input logic f,
			output bit fires, output rcdr_result_t rpt);
		int off;
		fires = 1'b0;
		rpt = '0;
		if (f) begin
			frame_pos = '0;
			even_sum = '0;
			odd_sum = '0;
			frame_fault = ST_OK;
			next_analog = '0;
			next_digital = '0;
		end
		if (frame_pos >= POS_IDLE)
			return;
		if (frame_pos[0])
			odd_sum ^= b;
		else
			even_sum ^= b;
		if (frame_pos == 6'd0 && b != HEADER0)
			frame_fault = ST_HEADER;
		if (frame_pos == 6'd1 && b != HEADER1)
			frame_fault = ST_HEADER;
		if (frame_pos == 6'd2 && frame_fault == ST_OK && b != TYPE_OK)
			frame_fault = ST_TYPE;
		if (frame_pos == 6'd3 && frame_fault == ST_OK && b != SUBTYPE_OK)
			frame_fault = ST_SUBTYPE;
		if (frame_pos >= ANALOG_FIRST && frame_pos < DIGITAL_FIRST)
			next_analog = {next_analog[55:0], b};
		if (frame_pos >= DIGITAL_FIRST && frame_pos < DIGITAL_FIRST + DIGITAL_BYTES) begin
			off = 8 * int'(frame_pos - DIGITAL_FIRST);
			next_digital |= 64'(b) << off;
		end
		if (frame_pos != POS_LAST) begin
			frame_pos++;
			return;
		end
		frame_pos = POS_IDLE;

		// Header beats check, check beats type and subtype
		if (frame_fault == ST_HEADER)
			rpt.status = ST_HEADER;
		else if (even_sum != 8'h00 || odd_sum != 8'h00)
			rpt.status = ST_CHECK;
		else
			rpt.status = frame_fault;

		if (rpt.status == ST_OK) begin
			for (int i = 0; i < 4; i++)
				held_analog[i] = next_analog[16 * (3 - i) +: 16];
			held_digital = next_digital;
			held_valid = 1'b1;
		end
		for (int i = 0; i < 4; i++)
			rpt.analog[i] = held_valid ? held_analog[i] : idle_value;
		rpt.digital = held_digital;
		fires = 1'b1;
	endtask

	// Well-formed frame with the requested corruptions
	task automatic build_frame(input fill_t fill, input logic [4:0] faults);
		logic [7:0] ev;
		logic [7:0] od;
		ev = '0;
		od = '0;
		frame_buf[0] = HEADER0;
		frame_buf[1] = HEADER1;
		frame_buf[2] = TYPE_OK;
		frame_buf[3] = SUBTYPE_OK;
		for (int k = 4; k < 30; k++) begin
			case (fill)
				FILL_ZERO: frame_buf[k] = 8'h00;
				FILL_ONES: frame_buf[k] = 8'hff;
				default:   frame_buf[k] = 8'($urandom_range(0, 255));
			endcase
		end
		if (faults & FAULT_HDR0)
			frame_buf[0] ^= 8'($urandom_range(1, 255));
		if (faults & FAULT_HDR1)
			frame_buf[1] ^= 8'($urandom_range(1, 255));
		if (faults & FAULT_TYPE)
			frame_buf[2] ^= 8'($urandom_range(1, 255));
		if (faults & FAULT_SUBTYPE)
			frame_buf[3] ^= 8'($urandom_range(1, 255));
		for (int k = 0; k < 30; k++) begin
			if (k % 2 == 0)
				ev ^= frame_buf[k];
			else
				od ^= frame_buf[k];
		end
		frame_buf[30] = ev;
		frame_buf[31] = od;
		if (faults & FAULT_CHECK)
			frame_buf[30 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
	endtask

	// Offer one byte, after a random gap unless gapless, and wait for its transfer
	task automatic send_byte(input logic [7:0] b, input logic f, input bit gapless,
			input bit counted);
		int gap;
		bit fires;
		rcdr_result_t rpt;
		gap = gapless ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= f;
		do @(posedge clk); while (!in_ready);
		datagram_absorb(b, f, fires, rpt);
		if (fires) begin
			if (typed_en)
				rpt.status = typed_st;
			expected_reports.push_back(rpt);
		end
		if (counted)
			items_sent++;
	endtask

	// Drain outstanding reports so the block is idle
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_idle_value(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		idle_value = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input logic cfg_en, input logic [15:0] cfg_val, input fill_t fill,
			input logic [4:0] faults, input int cut, input int trail, input logic typed,
			input logic [2:0] typed_status);
		frame_row_t row;
		row.cfg_en = cfg_en;
		row.cfg_val = cfg_val;
		row.fill = fill;
		row.faults = faults;
		row.cut = 6'(cut);
		row.trail = 3'(trail);
		row.typed = typed;
		row.typed_status = typed_status;
		directed_rows.push_back(row);
	endtask

	task automatic send_frame(input bit gapless, input int cut);
		for (int k = 0; k < cut; k++)
			send_byte(frame_buf[k], k == 0, gapless, 1'b1);
		for (int k = 0; k < 32; k++)
			send_byte(frame_buf[k], k == 0, gapless, 1'b1);
	endtask

	// Stimulus: directed frames, then random traffic
	initial begin : stimulus
		frame_row_t row;
		int frame_no;
		int kind;
		int n;
		int pick;
		bit gapless;
		fill_t fill;

		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		first_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad frames first so the idle value shows up in the reports
		add_row(1, 16'hffff, FILL_ZERO,   FAULT_HDR0, 0, 0, 1, ST_HEADER);
		add_row(0, 16'h0000, FILL_ONES,   FAULT_HDR1, 0, 0, 1, ST_HEADER);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_HDR0 | FAULT_TYPE | FAULT_CHECK, 0, 0, 1,
			ST_HEADER);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_CHECK, 0, 0, 1, ST_CHECK);
		add_row(1, 16'h0000, FILL_RANDOM, FAULT_TYPE, 0, 0, 1, ST_TYPE);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_SUBTYPE, 0, 0, 1, ST_SUBTYPE);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_TYPE | FAULT_SUBTYPE, 0, 0, 1, ST_TYPE);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_TYPE | FAULT_CHECK, 0, 3, 1, ST_CHECK);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_HDR1 | FAULT_SUBTYPE, 0, 0, 1, ST_HEADER);
		// Restart mid-frame, good frames with extreme payloads, a cut-off check fault, then a random good frame
		add_row(1, 16'h5a3c, FILL_RANDOM, FAULT_NONE, 17, 0, 1, ST_OK);
		add_row(0, 16'h0000, FILL_ZERO,   FAULT_NONE, 0, 0, 1, ST_OK);
		add_row(0, 16'h0000, FILL_ONES,   FAULT_NONE, 0, 2, 1, ST_OK);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_CHECK, 31, 0, 1, ST_CHECK);
		add_row(0, 16'h0000, FILL_RANDOM, FAULT_NONE, 0, 0, 0, ST_OK);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.cfg_en) begin
				settle_block();
				write_idle_value(row.cfg_val);
			end
			build_frame(row.fill, row.faults);
			typed_en = row.typed;
			typed_st = row.typed_status;
			send_frame(1'b0, int'(row.cut));
			for (int t = 0; t < int'(row.trail); t++)
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
			typed_en = 1'b0;
		end

		// Random traffic, mostly well-formed frames
		frame_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (frame_no % 12 == 11) begin
				settle_block();
				pick = $urandom_range(0, 2);
				write_idle_value(pick == 0 ? 16'h0000 :
					pick == 1 ? 16'hffff : 16'($urandom_range(0, 65535)));
			end
			if (frame_no == 4)
				hold_off_request = 1'b1;
			gapless = (frame_no >= 4 && frame_no <= 7) || $urandom_range(0, 3) == 0;
			pick = $urandom_range(0, 19);
			fill = pick == 0 ? FILL_ZERO : pick == 1 ? FILL_ONES : FILL_RANDOM;
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				build_frame(fill, FAULT_NONE);
				send_frame(gapless, 0);
			end else if (kind < 65) begin
				build_frame(fill, FAULT_HDR0 << $urandom_range(0, 4));
				send_frame(gapless, 0);
			end else if (kind < 75) begin
				build_frame(fill, 5'($urandom_range(1, 31)));
				send_frame(gapless, 0);
			end else if (kind < 85) begin
				// Truncated frame, ended by the next first-byte flag or continued by stray bytes
				build_frame(fill, FAULT_NONE);
				n = $urandom_range(1, 31);
				for (int k = 0; k < n; k++)
					send_byte(frame_buf[k], k == 0, gapless, 1'b1);
			end else if (kind < 92) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					send_byte(8'($urandom_range(0, 255)), 1'b0, gapless, 1'b0);
			end else begin
				n = $urandom_range(1, 40);
				for (int k = 0; k < n; k++)
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
						gapless, 1'b1);
			end
			frame_no++;
		end

		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Report sink: random stalls, calm stretches, one long hold-off
	initial begin : report_sink
		int stall;
		int calm_left;
		out_ready = 1'b0;
		calm_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else if (calm_left > 0) begin
				calm_left--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, 19);
				if ($urandom_range(0, 9) == 0)
					calm_left = $urandom_range(3, 10);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each report transfer with the oldest prediction
	always @(posedge clk) begin : report_check
		rcdr_result_t want;
		logic [15:0] got_analog [4];
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: status %0d", status);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				got_analog[0] = analog_ch1;
				got_analog[1] = analog_ch2;
				got_analog[2] = analog_ch3;
				got_analog[3] = analog_ch4;
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				for (int i = 0; i < 4; i++) begin
					if (got_analog[i] !== want.analog[i]) begin
						$error("analog_ch%0d: expected %h, got %h", i + 1,
							want.analog[i], got_analog[i]);
						mismatch_count++;
					end
				end
				if (digital_bits !== want.digital) begin
					$error("digital_bits: expected %h, got %h", want.digital, digital_bits);
					mismatch_count++;
				end
			end
		end
	end

	// Run-time limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule
